// ===== rtl/fir_pkg.sv =====
// Shared types, codes and widths for the 16-bit scaled FIR filter.
package fir_pkg;

    localparam int TAPS_DEF   = 32;   // default built tap depth
    localparam int SAMPLE_W   = 16;   // sample, coefficient and output width
    localparam int CFG_W      = 15;   // widest configuration register
    localparam int TAPCNT_W   = 6;    // tap count register width
    localparam int CIDX_W     = 5;    // coefficient index field width
    localparam int CFG_IDX_W  = 1;    // configuration register index width
    localparam int QUO_W      = 18;   // quotient bits developed by the divider
    localparam int DEN_W      = CFG_W + QUO_W - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_CNT  = 1'b1;

    localparam logic [CFG_W-1:0]    SCALE_RST    = 15'd1;
    localparam logic [TAPCNT_W-1:0] TAP_CNT_RST  = 6'd32;

    localparam logic [QUO_W-1:0]    QUO_POS_MAX  = 18'd32767;
    localparam logic [QUO_W-1:0]    QUO_NEG_MAX  = 18'd32768;
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        OP_FILTER = 2'd0,
        OP_COEF   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DIV
    } t_state;

    typedef struct packed {
        logic [1:0]                  op;
        logic signed [SAMPLE_W-1:0]  sample;
        logic [CIDX_W-1:0]           coef_index;
        logic signed [SAMPLE_W-1:0]  coef_value;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  filtered;
        logic                        clipped;
    } t_out;

endpackage

// ===== rtl/fir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fir_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fir_div.sv =====
// Restoring divider: sum / scale, truncated toward zero, saturated to 16 bits.
module fir_div import fir_pkg::*; #(
    parameter int ACC_W = 40
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_acc,
    input  logic [CFG_W-1:0]        i_scale,
    output logic                    o_done,
    output t_out                    o_res
);

    localparam int CNT_W = $clog2(QUO_W);

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [ACC_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;

    logic [CFG_W-1:0]  w_scale;
    logic              w_ge;
    logic              w_clip;

    assign w_scale = (i_scale == '0) ? CFG_W'(1) : i_scale;
    assign w_ge    = r_rem >= ACC_W'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_neg  <= i_acc[ACC_W-1];
            r_rem  <= i_acc[ACC_W-1] ? ACC_W'(-i_acc) : ACC_W'(i_acc);
            r_den  <= {w_scale, (QUO_W-1)'(0)};
            r_quo  <= '0;
            r_cnt  <= CNT_W'(QUO_W - 1);
        end else if (r_busy) begin
            // one quotient bit a step; a set top bit already means clip
            if (w_ge) begin
                r_rem <= r_rem - ACC_W'(r_den);
            end
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_den <= r_den >> 1;
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_comb begin
        if (r_neg) begin
            w_clip         = r_quo > QUO_NEG_MAX;
            o_res.filtered = w_clip ? OUT_MIN : SAMPLE_W'(~r_quo + QUO_W'(1));
        end else begin
            w_clip         = r_quo > QUO_POS_MAX;
            o_res.filtered = w_clip ? OUT_MAX : SAMPLE_W'(r_quo);
        end
        o_res.clipped = w_clip;
    end

    assign o_done = r_done;

endmodule

// ===== rtl/fir_filter_int16_scaled.sv =====
// Top level of the 16-bit direct-form FIR filter with integer output scaling.
//
//  channel  | direction | handshake                 | beat contents
//  ---------+-----------+---------------------------+-------------------------------
//  in       | input     | i_in_valid / o_in_ready   | t_in: op, sample, coef_index,
//           |           |                           |       coef_value
//  out      | output    | o_out_valid / i_out_ready | t_out: filtered, clipped
//  cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// After a filter beat is accepted its result is made in order, n being the taps in use:
// one tap a cycle through the single multiplier, the product pipeline draining into
// the sum, 18 restoring-divider steps, then the load into the output register once free.
// Coefficient, clear and unused-op beats are handled at acceptance; no tap walk follows.
// Reset is synchronous and active low: valid bits stand in for zeroed history
// and coefficients, so there is no clearing pass.
// The input is not ready while a filter beat is at work; a finished result may
// wait in the output register while the next beat is accepted.
module fir_filter_int16_scaled import fir_pkg::*; #(
    parameter int TAPS = TAPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;   // ring/coef address
    localparam int CW    = $clog2(TAPS + 1);                // tap counter
    localparam int ACC_W = 2 * SAMPLE_W + AW + 1;           // exact sum of all taps

    // configuration registers
    logic [CFG_W-1:0]    r_scale;
    logic [TAPCNT_W-1:0] r_tap_cnt;

    // sequencer
    t_state              r_state, n_state;
    logic                w_in_acc;
    logic                w_issue;
    logic                w_div_start;
    logic                w_out_load;
    logic [CW-1:0]       w_ntaps;

    // history ring and coefficient store
    logic [AW-1:0]       r_newest;
    logic [AW-1:0]       w_newest_nxt;
    logic [TAPS-1:0]     r_hvld;
    logic [TAPS-1:0]     r_cvld;
    logic                w_hist_we;
    logic                w_coef_we;
    logic [SAMPLE_W-1:0] w_hist_rd;
    logic [SAMPLE_W-1:0] w_coef_rd;

    // multiply-accumulate pipeline
    logic [CW-1:0]              r_tap;
    logic [AW-1:0]              r_rptr;
    logic                       r_s1_vld;
    logic                       r_s1_cv;
    logic                       r_s1_hv;
    logic                       r_s2_vld;
    logic signed [SAMPLE_W-1:0] w_mul_c;
    logic signed [SAMPLE_W-1:0] w_mul_x;
    logic signed [2*SAMPLE_W-1:0] r_prod;
    logic signed [ACC_W-1:0]    r_acc;

    // divider and output register
    logic                w_div_done;
    t_out                w_div_res;
    logic                r_out_vld;
    t_out                r_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;

    // Configuration: take a beat whenever offered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= SCALE_RST;
            r_tap_cnt <= TAP_CNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SCALE:   r_scale   <= i_cfg_data;
                CFG_TAP_CNT: r_tap_cnt <= i_cfg_data[TAPCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the tap count to the built depth.
    assign w_ntaps = (32'(r_tap_cnt) > 32'(TAPS)) ? CW'(TAPS) : CW'(r_tap_cnt);

    // Advance the ring position with wrap; the new sample lands there.
    assign w_newest_nxt = (r_newest == AW'(TAPS - 1)) ? '0 : r_newest + AW'(1);

    assign w_hist_we = w_in_acc && (i_in.op == OP_FILTER);
    assign w_coef_we = w_in_acc && (i_in.op == OP_COEF)
                       && (32'(i_in.coef_index) < 32'(TAPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
            r_hvld   <= '0;
            r_cvld   <= '0;
        end else if (w_in_acc) begin
            unique case (i_in.op)
                OP_FILTER: begin
                    r_newest               <= w_newest_nxt;
                    r_hvld[w_newest_nxt]   <= 1'b1;
                end
                OP_COEF: begin
                    if (w_coef_we) begin
                        r_cvld[AW'(i_in.coef_index)] <= 1'b1;
                    end
                end
                OP_CLEAR: begin
                    // drop the whole history at once; coefficients stay
                    r_newest <= '0;
                    r_hvld   <= '0;
                end
                default: ;
            endcase
        end
    end

    fir_ram #(
        .W     (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_newest_nxt),
        .i_wdata (i_in.sample),
        .i_raddr (r_rptr),
        .o_rdata (w_hist_rd)
    );

    fir_ram #(
        .W     (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (AW'(i_in.coef_index)),
        .i_wdata (i_in.coef_value),
        .i_raddr (r_tap[AW-1:0]),
        .o_rdata (w_coef_rd)
    );

    // Sequencer: idle -> walk the taps -> divide -> hand the result over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_issue     = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in.op == OP_FILTER)) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                w_issue = (r_tap < w_ntaps);
                // start the divide once every product has landed in the sum
                if (!w_issue && !r_s1_vld && !r_s2_vld) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done && (!r_out_vld || i_out_ready)) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Tap walk: coefficient i against the sample i places older than newest.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.op == OP_FILTER)) begin
            r_tap  <= '0;
            r_rptr <= w_newest_nxt;
            r_acc  <= '0;
        end else begin
            if (w_issue) begin
                r_tap  <= r_tap + CW'(1);
                r_rptr <= (r_rptr == '0) ? AW'(TAPS - 1) : r_rptr - AW'(1);
            end
            if (r_s2_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        r_s1_cv <= r_cvld[r_tap[AW-1:0]];
        r_s1_hv <= r_hvld[r_rptr];
        r_prod  <= w_mul_c * w_mul_x;
    end

    // Entries never written since reset or clear read as zero.
    assign w_mul_c = r_s1_cv ? $signed(w_coef_rd) : '0;
    assign w_mul_x = r_s1_hv ? $signed(w_hist_rd) : '0;

    fir_div #(
        .ACC_W (ACC_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_acc   (r_acc),
        .i_scale (r_scale),
        .o_done  (w_div_done),
        .o_res   (w_div_res)
    );

    // Output register: hold the result until the consumer takes the beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_out_load) begin
            r_out <= w_div_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_MAC) |-> (!r_s1_vld && !r_s2_vld))
        else $error("tap pipeline busy outside the tap walk");

    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_tap <= w_ntaps))
        else $error("tap counter ran past the taps in use");

    a_filter_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.op == OP_FILTER)) |=> (r_state == S_MAC && r_tap == '0))
        else $error("filter beat did not start a tap walk");

    a_load_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (w_div_done && !w_div_start))
        else $error("result loaded before the divider finished");

    a_div_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> !w_div_done)
        else $error("divider still flags done after a new start");

endmodule
